// ----- hdl/tcma_pkg.sv -----
package tcma_pkg;

  // converter sample width, also the width of every average
  localparam int SAMPLE_W = 10;
  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;

  // per-item control shared by all lanes
  typedef struct packed {
    logic load;      // take the beat's sample, read the ring slot
    logic update;    // swap the slot, update the sum, seed the divider
    logic div_step;  // one quotient bit
  } lane_ctrl_t;

endpackage

// ----- hdl/tcma_ram.sv -----
module tcma_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 20
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/tcma_lane.sv -----
module tcma_lane #(
  parameter int WINDOW = 20
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  tcma_pkg::lane_ctrl_t                         ctrl,
  input  logic [tcma_pkg::SAMPLE_W-1:0]                sample,
  input  logic [(WINDOW > 1 ? $clog2(WINDOW) : 1)-1:0] pos,
  input  logic                                         filled,
  input  logic [$clog2(WINDOW+1)-1:0]                  count,
  output logic [tcma_pkg::SAMPLE_W-1:0]                average
);
  import tcma_pkg::*;

  localparam int SUM_W = $clog2(WINDOW * SAMPLE_MAX + 1);
  localparam int CNT_W = $clog2(WINDOW + 1);

  logic [SAMPLE_W-1:0] sample_q;
  logic [SAMPLE_W-1:0] old_sample;
  logic [SAMPLE_W-1:0] leaving;
  logic [SUM_W-1:0]    sum;
  logic [SUM_W-1:0]    sum_next;
  logic [SUM_W-1:0]    dvd;
  logic [CNT_W-1:0]    rem;
  logic [CNT_W:0]      trial;
  logic [CNT_W:0]      diff;
  logic                ge;

  tcma_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW)) u_ring (
    .clk   (clk),
    .we    (ctrl.update),
    .waddr (pos),
    .wdata (sample_q),
    .re    (ctrl.load),
    .raddr (pos),
    .rdata (old_sample)
  );

  // slot not yet written since reset counts as zero
  assign leaving  = filled ? old_sample : '0;
  assign sum_next = sum + SUM_W'(sample_q) - SUM_W'(leaving);

  // restoring divide, one bit per step
  assign trial = {rem, dvd[SUM_W-1]};
  assign ge    = trial >= {1'b0, count};
  assign diff  = trial - {1'b0, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctrl.update) begin
      sum <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sample_q <= sample;
    end
    if (ctrl.update) begin
      dvd <= sum_next;
      rem <= '0;
    end else if (ctrl.div_step) begin
      dvd <= {dvd[SUM_W-2:0], ge};
      rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign average = dvd[SAMPLE_W-1:0];

endmodule

// ----- hdl/three_channel_moving_average.sv -----
// steps: accept beat and ring read, sum update in S_READ, SUM_W divide steps in S_DIV
//   (15 at WINDOW = 20), merge in S_DONE, which waits while the output is held
// the lanes' bit-serial dividers take one item at a time: in_ready is high only in S_IDLE
// the next item is taken while a finished result still waits at the output register
// reset (rst, synchronous): sums, counters, offset and handshakes cleared; ring memories
//   are not swept, unwritten slots are masked by the samples-seen count
module three_channel_moving_average #(
  parameter int WINDOW = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tcma_pkg::SAMPLE_W-1:0] voltage_sample,
  input  logic [tcma_pkg::SAMPLE_W-1:0] current_sample,
  input  logic [tcma_pkg::SAMPLE_W-1:0] pressure_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tcma_pkg::SAMPLE_W-1:0] voltage_average,
  output logic [tcma_pkg::SAMPLE_W-1:0] current_average,
  output logic [tcma_pkg::SAMPLE_W-1:0] pressure_average,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tcma_pkg::SAMPLE_W-1:0] cfg_data
);
  import tcma_pkg::*;

  localparam int SUM_W  = $clog2(WINDOW * SAMPLE_MAX + 1);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int POS_W  = WINDOW > 1 ? $clog2(WINDOW) : 1;
  localparam int STEP_W = $clog2(SUM_W);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t              state;
  state_t              state_next;
  lane_ctrl_t          ctrl;
  logic [POS_W-1:0]    pos;
  logic [CNT_W-1:0]    seen;
  logic                filled;
  logic [STEP_W-1:0]   step;
  logic [SAMPLE_W-1:0] offset;
  logic [SAMPLE_W-1:0] v_avg;
  logic [SAMPLE_W-1:0] c_avg;
  logic [SAMPLE_W-1:0] p_avg;
  logic [SAMPLE_W-1:0] c_trim;
  logic                in_beat;
  logic                out_load;

  // input side is free whenever no item is in flight
  assign in_ready = (state == S_IDLE);
  assign in_beat  = in_valid && in_ready;
  // output register takes a result once its previous beat has gone
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  // offset register, written at any time, used only in the merge cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
    end else if (cfg_valid && cfg_ready) begin
      offset <= cfg_data;
    end
  end

  // lane control
  always_comb begin
    ctrl.load     = in_beat;
    ctrl.update   = (state == S_READ);
    ctrl.div_step = (state == S_DIV);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (step == '0) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pos    <= '0;
      seen   <= '0;
      filled <= 1'b0;
      step   <= '0;
    end else begin
      state <= state_next;
      if (in_beat) begin
        // slot at pos holds live data only once the ring has wrapped
        filled <= (seen == CNT_W'(WINDOW));
        if (seen != CNT_W'(WINDOW)) begin
          seen <= seen + 1'b1;
        end
      end
      if (state == S_READ) begin
        pos  <= (pos == POS_W'(WINDOW - 1)) ? '0 : pos + 1'b1;
        step <= STEP_W'(SUM_W - 1);
      end else if (state == S_DIV) begin
        step <= step - 1'b1;
      end
    end
  end

  // three lanes, one per channel, sharing position and count
  tcma_lane #(.WINDOW(WINDOW)) u_lane_v (
    .clk (clk), .rst (rst), .ctrl (ctrl), .sample (voltage_sample),
    .pos (pos), .filled (filled), .count (seen), .average (v_avg)
  );

  tcma_lane #(.WINDOW(WINDOW)) u_lane_c (
    .clk (clk), .rst (rst), .ctrl (ctrl), .sample (current_sample),
    .pos (pos), .filled (filled), .count (seen), .average (c_avg)
  );

  tcma_lane #(.WINDOW(WINDOW)) u_lane_p (
    .clk (clk), .rst (rst), .ctrl (ctrl), .sample (pressure_sample),
    .pos (pos), .filled (filled), .count (seen), .average (p_avg)
  );

  // merge: remove the zero-current offset, floor at zero
  assign c_trim = (c_avg > offset) ? (c_avg - offset) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      voltage_average  <= v_avg;
      current_average  <= c_trim;
      pressure_average <= p_avg;
    end
  end

  // the sample count never passes the window
  a_seen_range: assert property (@(posedge clk) disable iff (rst)
    seen <= CNT_W'(WINDOW))
    else $error("samples seen beyond window");

  // the write slot stays inside the ring
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(WINDOW - 1))
    else $error("write position outside ring");

  // an accepted beat starts the ring read
  a_accept_read: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_READ)
    else $error("accepted beat not followed by ring read");

  // a fresh result only comes from a finished divide
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised without finished divide");

  // the count moves only on an accepted beat
  a_seen_move: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && in_ready) |=> $stable(seen))
    else $error("sample count changed without a beat");

endmodule
